@@ sv/pls_pkg.sv @@
// Shared types, codes and widths for the positional list store.
`timescale 1ns / 1ps

package pls_pkg;

    localparam int PLS_DEPTH         = 16;
    localparam int PLS_ELEMENT_WIDTH = 32;

    localparam int OPC_W       = 2;
    localparam int POS_W       = 8;
    localparam int VAL_W       = 32;
    localparam int STAT_W      = 2;
    localparam int CNT_OUT_W   = 5;
    localparam int IN_TDATA_W  = 48;
    localparam int OUT_TDATA_W = 40;

    // remainder unit: bits of position resolved per cycle
    localparam int MOD_BITS  = 2;
    localparam int MOD_ITERS = POS_W / MOD_BITS;
    localparam int ITER_W    = $clog2(MOD_ITERS);

    localparam logic [OPC_W-1:0] OP_INSERT = 2'd0;
    localparam logic [OPC_W-1:0] OP_REMOVE = 2'd1;
    localparam logic [OPC_W-1:0] OP_READ   = 2'd2;

    localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
    localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd1;
    localparam logic [STAT_W-1:0] STAT_FULL  = 2'd2;

    typedef struct packed {
        logic capture;
        logic mod_start;
        logic exec;
    } pls_cmd_t;

    typedef struct packed {
        logic need_mod;
        logic mod_done;
    } pls_stat_t;

endpackage

@@ sv/pls_rem.sv @@
// Iterative remainder unit: position modulo count, two bits per cycle.
`timescale 1ns / 1ps

module pls_rem
    import pls_pkg::*;
#(
    parameter int CW = 5
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic [POS_W-1:0] dividend,
    input  logic [CW-1:0]    divisor,
    output logic             done,
    output logic [CW-1:0]    remainder
);

    logic [CW-1:0]     rem_reg, rem_next;
    logic [POS_W-1:0]  dvd_reg, dvd_next;
    logic [ITER_W-1:0] iter_reg;
    logic              busy_reg;
    logic              done_reg;
    logic [CW:0]       trial;

    always_comb begin
        rem_next = rem_reg;
        dvd_next = dvd_reg;
        trial    = '0;
        for (int k = 0; k < MOD_BITS; k++) begin
            trial    = {rem_next, dvd_next[POS_W-1]};
            dvd_next = {dvd_next[POS_W-2:0], 1'b0};
            if (trial >= {1'b0, divisor}) begin
                trial = trial - {1'b0, divisor};
            end
            rem_next = trial[CW-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            iter_reg <= '0;
        end else if (start) begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            iter_reg <= '0;
        end else if (busy_reg) begin
            iter_reg <= iter_reg + 1'b1;
            if (iter_reg == ITER_W'(MOD_ITERS - 1)) begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg <= '0;
            dvd_reg <= dividend;
        end else if (busy_reg) begin
            rem_reg <= rem_next;
            dvd_reg <= dvd_next;
        end
    end

    assign done      = done_reg;
    assign remainder = rem_reg;

endmodule

@@ sv/pls_dp.sv @@
// Datapath: request registers, shifting element store, count and result word.
`timescale 1ns / 1ps

module pls_dp
    import pls_pkg::*;
#(
    parameter int DEPTH         = PLS_DEPTH,
    parameter int ELEMENT_WIDTH = PLS_ELEMENT_WIDTH
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  pls_cmd_t              cmd,
    output pls_stat_t             st,
    input  logic [IN_TDATA_W-1:0] in_word,
    output logic [OUT_TDATA_W-1:0] out_word
);

    localparam int CW    = $clog2(DEPTH + 1);
    localparam int IW    = $clog2(DEPTH);
    localparam int CMP_W = (POS_W > CW) ? POS_W : CW;

    logic [OPC_W-1:0]         op_reg;
    logic [POS_W-1:0]         pos_reg;
    logic [VAL_W-1:0]         val_reg;
    logic [CW-1:0]            count_reg, count_next;
    logic [ELEMENT_WIDTH-1:0] elem_reg [DEPTH];

    logic [VAL_W-1:0]     out_value_reg, out_value_next;
    logic [STAT_W-1:0]    out_status_reg, out_status_next;
    logic [CNT_OUT_W-1:0] out_count_reg;

    logic                     mod_done;
    logic [CW-1:0]            mod_rem;
    logic [CMP_W-1:0]         pos_x, cnt_x;
    logic                     full, empty, do_ins, do_rem;
    logic [IW-1:0]            ins_idx, rem_idx, rd_idx;
    logic [ELEMENT_WIDTH-1:0] rd_data, store_in;
    logic [63:0]              val_wide, rd_wide;
    logic [31:0]              cnt_wide;

    pls_rem #(.CW(CW)) u_rem (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (cmd.mod_start),
        .dividend  (pos_reg),
        .divisor   (count_reg),
        .done      (mod_done),
        .remainder (mod_rem)
    );

    always_comb begin
        pos_x  = CMP_W'(pos_reg);
        cnt_x  = CMP_W'(count_reg);
        full   = (count_reg == CW'(DEPTH));
        empty  = (count_reg == '0);
        do_ins = (op_reg == OP_INSERT) && !full;
        do_rem = (op_reg == OP_REMOVE) && !empty;

        ins_idx = (pos_x > cnt_x) ? count_reg[IW-1:0] : IW'(pos_reg);
        rem_idx = (pos_x >= cnt_x) ? IW'(count_reg - 1'b1) : IW'(pos_reg);
        rd_idx  = (op_reg == OP_READ) ? mod_rem[IW-1:0] : rem_idx;
        rd_data = elem_reg[rd_idx];

        val_wide = 64'(val_reg);
        store_in = val_wide[ELEMENT_WIDTH-1:0];
        rd_wide  = 64'(rd_data);

        st.need_mod = (op_reg == OP_READ) && !empty;
        st.mod_done = mod_done;

        count_next      = count_reg;
        out_value_next  = '0;
        out_status_next = STAT_OK;
        unique case (op_reg)
            OP_INSERT: begin
                if (full) out_status_next = STAT_FULL;
                else      count_next = count_reg + 1'b1;
            end
            OP_REMOVE: begin
                if (empty) begin
                    out_status_next = STAT_EMPTY;
                end else begin
                    out_value_next = rd_wide[31:0];
                    count_next     = count_reg - 1'b1;
                end
            end
            OP_READ: begin
                if (empty) out_status_next = STAT_EMPTY;
                else       out_value_next  = rd_wide[31:0];
            end
            default: ;
        endcase
        cnt_wide = 32'(count_next);
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            op_reg  <= in_word[OPC_W-1:0];
            pos_reg <= in_word[OPC_W +: POS_W];
            val_reg <= in_word[OPC_W + POS_W +: VAL_W];
        end
        if (cmd.exec) begin
            out_value_reg  <= out_value_next;
            out_status_reg <= out_status_next;
            out_count_reg  <= cnt_wide[CNT_OUT_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else if (cmd.exec) begin
            count_reg <= count_next;
        end
    end

    for (genvar g = 0; g < DEPTH; g++) begin : g_elem
        always_ff @(posedge aclk) begin
            if (cmd.exec && do_ins) begin
                if (IW'(g) == ins_idx) begin
                    elem_reg[g] <= store_in;
                end else if (g > 0 && IW'(g) > ins_idx) begin
                    elem_reg[g] <= elem_reg[(g > 0) ? g - 1 : 0];
                end
            end else if (cmd.exec && do_rem) begin
                if (g < DEPTH - 1 && IW'(g) >= rem_idx) begin
                    elem_reg[g] <= elem_reg[(g < DEPTH - 1) ? g + 1 : g];
                end
            end
        end
    end

    assign out_word = {{(OUT_TDATA_W - VAL_W - STAT_W - CNT_OUT_W){1'b0}},
                       out_count_reg, out_status_reg, out_value_reg};

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CW'(DEPTH))
        else $error("element count beyond depth");

    a_read_index: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.exec && op_reg == OP_READ && !empty) |-> (mod_done && mod_rem < count_reg))
        else $error("read index not reduced below count");

    a_insert_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.exec && do_ins) |=> (count_reg == $past(count_reg) + 1'b1))
        else $error("insert did not grow the list");

endmodule

@@ sv/pls_ctrl.sv @@
// Controller: request sequencing and output word valid.
`timescale 1ns / 1ps

module pls_ctrl
    import pls_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_axis_tvalid,
    output logic      s_axis_tready,
    output logic      m_axis_tvalid,
    input  logic      m_axis_tready,
    output pls_cmd_t  cmd,
    input  pls_stat_t st
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_DECODE,
        S_DIV,
        S_EXEC
    } state_t;

    state_t state_reg, state_next;
    logic   m_tvalid_reg, m_tvalid_next;

    always_comb begin
        state_next    = state_reg;
        m_tvalid_next = m_tvalid_reg;
        cmd           = '0;
        if (m_tvalid_reg && m_axis_tready) m_tvalid_next = 1'b0;
        unique case (state_reg)
            S_IDLE: begin
                if (s_axis_tvalid) begin
                    cmd.capture = 1'b1;
                    state_next  = S_DECODE;
                end
            end
            S_DECODE: begin
                if (st.need_mod) begin
                    cmd.mod_start = 1'b1;
                    state_next    = S_DIV;
                end else begin
                    state_next = S_EXEC;
                end
            end
            S_DIV: begin
                if (st.mod_done) state_next = S_EXEC;
            end
            S_EXEC: begin
                if (!m_tvalid_reg || m_axis_tready) begin
                    cmd.exec      = 1'b1;
                    m_tvalid_next = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    assign s_axis_tready = (state_reg == S_IDLE);
    assign m_axis_tvalid = m_tvalid_reg;

endmodule

@@ sv/positional_list_store.sv @@
// Top level of the positional list store: insert, remove and read by position.
//
//  channel   dir  tdata fields (lowest bit up)                    width
//  s_axis    in   opcode[1:0] position[9:2] value[41:10]           48
//  m_axis    out  result_value[31:0] status[33:32] count[38:34]    40
//
//  Insert, remove and the unused opcode: the request is captured on accept, decoded,
//  then executed into the result registers; a new word is taken only back in idle.
//  Read: after decode the remainder unit wraps the position by the count, two bits
//  per cycle, and signals done before the execute step; a read of an empty list skips it.
//  A low m_axis_tready holds the result; the next request stalls only at its last step.
//  Reset (aresetn low, synchronous) empties the list; stored entries keep junk.
`timescale 1ns / 1ps

module positional_list_store
    import pls_pkg::*;
#(
    parameter int DEPTH         = PLS_DEPTH,
    parameter int ELEMENT_WIDTH = PLS_ELEMENT_WIDTH
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // opcode, position, value
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // result_value, status, count
    output logic [OUT_TDATA_W-1:0] m_axis_tdata
);

    pls_cmd_t  cmd;
    pls_stat_t st;

    pls_ctrl u_ctrl (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .cmd           (cmd),
        .st            (st)
    );

    pls_dp #(
        .DEPTH         (DEPTH),
        .ELEMENT_WIDTH (ELEMENT_WIDTH)
    ) u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .st       (st),
        .in_word  (s_axis_tdata),
        .out_word (m_axis_tdata)
    );

endmodule

@@ tb/positional_list_store_tb.sv @@
// Self-checking testbench for the positional list store: directed table, then random traffic.
`timescale 1ns / 1ps

module positional_list_store_tb;
    import pls_pkg::*;

    localparam int                LIST_DEPTH     = PLS_DEPTH;
    localparam logic [OPC_W-1:0]  OP_SPARE       = 2'd3;
    localparam int                RANDOM_WORDS   = 1700;
    localparam int                WATCHDOG_LIMIT = 2000;
    localparam int                DRAIN_CYCLES   = 16;

    typedef struct packed {
        logic [VAL_W-1:0]     value;
        logic [STAT_W-1:0]    status;
        logic [CNT_OUT_W-1:0] count;
    } list_result_t;

    typedef struct {
        bit           pinned;
        list_result_t res;
    } pinned_t;

    typedef struct {
        logic [OPC_W-1:0] op;
        logic [POS_W-1:0] pos;
        logic [VAL_W-1:0] val;
        int               reps;
        bit               pinned;
        list_result_t     res;
    } stim_row_t;

    logic                   aclk;
    logic                   aresetn;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;

    positional_list_store uut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // shadow copy of the list
    logic [VAL_W-1:0] list_mem [LIST_DEPTH];
    int               list_len;

    list_result_t     result_q [$];
    pinned_t          pinned_q [$];
    stim_row_t        table_q  [$];

    int  mismatches;
    int  idle_cycles;
    int  words_in;
    int  full_refusals;
    int  empty_refusals;
    int  reads_done;
    int  peak_len;
    bit  no_stall;
    bit  timed_out;

    list_result_t predicted;
    list_result_t observed;
    pinned_t      pin;

    always begin
        aclk = 1'b1;
        #5;
        aclk = 1'b0;
        #5;
    end

    task automatic predict_request(input logic [OPC_W-1:0] op, input logic [POS_W-1:0] pos,
                                   input logic [VAL_W-1:0] val, output list_result_t res);
        int p;
        int i;
        p          = pos;
        res.value  = '0;
        res.status = STAT_OK;
        case (op)
            OP_INSERT: begin
                if (list_len >= LIST_DEPTH) begin
                    res.status = STAT_FULL;
                    full_refusals++;
                end else begin
                    if (p > list_len) p = list_len;
                    for (i = list_len; i > p; i--) list_mem[i] = list_mem[i-1];
                    list_mem[p] = val;
                    list_len++;
                end
            end
            OP_REMOVE: begin
                if (list_len == 0) begin
                    res.status = STAT_EMPTY;
                    empty_refusals++;
                end else begin
                    if (p >= list_len) p = list_len - 1;
                    res.value = list_mem[p];
                    for (i = p; i + 1 < list_len; i++) list_mem[i] = list_mem[i+1];
                    list_len--;
                end
            end
            OP_READ: begin
                if (list_len == 0) begin
                    res.status = STAT_EMPTY;
                    empty_refusals++;
                end else begin
                    res.value = list_mem[p % list_len];
                    reads_done++;
                end
            end
            default: ;
        endcase
        res.count = list_len[CNT_OUT_W-1:0];
        if (list_len > peak_len) peak_len = list_len;
    endtask

    always @(posedge aclk) begin
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            observed.value  = m_axis_tdata[31:0];
            observed.status = m_axis_tdata[33:32];
            observed.count  = m_axis_tdata[38:34];
            if (result_q.size() == 0) begin
                $error("unexpected result word: value %h status %0d count %0d",
                       observed.value, observed.status, observed.count);
                mismatches++;
            end else begin
                predicted = result_q.pop_front();
                if (observed.value !== predicted.value) begin
                    $error("result_value: expected %h, got %h", predicted.value, observed.value);
                    mismatches++;
                end
                if (observed.status !== predicted.status) begin
                    $error("status: expected %0d, got %0d", predicted.status, observed.status);
                    mismatches++;
                end
                if (observed.count !== predicted.count) begin
                    $error("count: expected %0d, got %0d", predicted.count, observed.count);
                    mismatches++;
                end
            end
        end
        if (aresetn && s_axis_tvalid && s_axis_tready) begin
            predict_request(s_axis_tdata[1:0], s_axis_tdata[9:2], s_axis_tdata[41:10],
                            predicted);
            pin.pinned = 1'b0;
            if (pinned_q.size() != 0) pin = pinned_q.pop_front();
            result_q.push_back(pin.pinned ? pin.res : predicted);
            words_in++;
        end
        if (aresetn && ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
    end

    always @(negedge aclk) begin
        if (aresetn)
            m_axis_tready <= no_stall ? 1'b1 : ($urandom_range(0, 99) >= 36);
    end

    // called at a falling edge; returns at the falling edge after acceptance
    task automatic send_word(input logic [OPC_W-1:0] op, input logic [POS_W-1:0] pos,
                             input logic [VAL_W-1:0] val, input bit pinned,
                             input list_result_t res);
        pinned_t entry;
        entry.pinned = pinned;
        entry.res    = res;
        while (!no_stall && $urandom_range(0, 99) < 36) begin
            s_axis_tvalid = 1'b0;
            s_axis_tdata  = IN_TDATA_W'({$urandom, $urandom});
            @(negedge aclk);
        end
        pinned_q.push_back(entry);
        s_axis_tvalid = 1'b1;
        s_axis_tdata  = {{(IN_TDATA_W-OPC_W-POS_W-VAL_W){1'b0}}, val, pos, op};
        do @(posedge aclk); while (!(s_axis_tvalid && s_axis_tready));
        @(negedge aclk);
    endtask

    task automatic add_row(input logic [OPC_W-1:0] op, input logic [POS_W-1:0] pos,
                           input logic [VAL_W-1:0] val, input int reps, input bit pinned,
                           input logic [VAL_W-1:0] e_val, input logic [STAT_W-1:0] e_stat,
                           input logic [CNT_OUT_W-1:0] e_cnt);
        stim_row_t row;
        row.op         = op;
        row.pos        = pos;
        row.val        = val;
        row.reps       = reps;
        row.pinned     = pinned;
        row.res.value  = e_val;
        row.res.status = e_stat;
        row.res.count  = e_cnt;
        table_q.push_back(row);
    endtask

    task automatic run_stimulus();
        stim_row_t        row;
        list_result_t     blank;
        logic [OPC_W-1:0] op;
        logic [POS_W-1:0] pos;
        logic [VAL_W-1:0] val;
        int               mode;
        int               r;
        int               k;
        blank = '0;

        //      op         pos      value          reps pin exp value     exp status  cnt
        add_row(OP_READ,   8'd0,   32'h0000_0000, 1,   1, 32'h0000_0000, STAT_EMPTY, 5'd0);
        add_row(OP_REMOVE, 8'd255, 32'hFFFF_FFFF, 1,   1, 32'h0000_0000, STAT_EMPTY, 5'd0);
        add_row(OP_SPARE,  8'd255, 32'hFFFF_FFFF, 1,   1, 32'h0000_0000, STAT_OK,    5'd0);
        add_row(OP_INSERT, 8'd255, 32'h7FFF_FFFF, 1,   1, 32'h0000_0000, STAT_OK,    5'd1);
        add_row(OP_READ,   8'd255, 32'h0000_0000, 1,   1, 32'h7FFF_FFFF, STAT_OK,    5'd1);
        add_row(OP_REMOVE, 8'd0,   32'h0000_0000, 1,   1, 32'h7FFF_FFFF, STAT_OK,    5'd0);
        add_row(OP_INSERT, 8'd0,   32'h8000_0000, 1,   1, 32'h0000_0000, STAT_OK,    5'd1);
        add_row(OP_INSERT, 8'd0,   32'h0000_0100, 15,  0, 32'h0000_0000, STAT_OK,    5'd0);
        add_row(OP_INSERT, 8'd128, 32'h0000_0000, 1,   1, 32'h0000_0000, STAT_FULL,  5'd16);
        add_row(OP_READ,   8'd255, 32'h0000_0000, 1,   0, 32'h0000_0000, STAT_OK,    5'd0);
        add_row(OP_READ,   8'd16,  32'h0000_0000, 1,   0, 32'h0000_0000, STAT_OK,    5'd0);
        add_row(OP_SPARE,  8'd0,   32'h0000_0000, 1,   1, 32'h0000_0000, STAT_OK,    5'd16);
        add_row(OP_REMOVE, 8'd255, 32'h0000_0000, 1,   1, 32'h8000_0000, STAT_OK,    5'd15);
        add_row(OP_INSERT, 8'd7,   32'hFFFF_FFFF, 1,   0, 32'h0000_0000, STAT_OK,    5'd0);
        add_row(OP_READ,   8'd7,   32'h0000_0000, 1,   0, 32'h0000_0000, STAT_OK,    5'd0);

        foreach (table_q[i]) begin
            row = table_q[i];
            for (k = 0; k < row.reps; k++)
                send_word(row.op, row.pos, row.val + k, row.pinned, row.res);
        end

        // random part: phases that fill, drain, churn, or favour reads
        mode = 0;
        for (k = 0; k < RANDOM_WORDS; k++) begin
            if (k % 50 == 0) mode = $urandom_range(0, 3);
            no_stall = (k >= 700 && k < 1000);
            r = $urandom_range(0, 99);
            if (r < 3)
                op = OP_SPARE;
            else case (mode)
                0:       op = (r < 70) ? OP_INSERT : (r < 85) ? OP_READ : OP_REMOVE;
                1:       op = (r < 70) ? OP_REMOVE : (r < 85) ? OP_READ : OP_INSERT;
                2:       op = (r < 45) ? OP_INSERT : (r < 85) ? OP_REMOVE : OP_READ;
                default: op = (r < 30) ? OP_INSERT : (r < 55) ? OP_REMOVE : OP_READ;
            endcase
            r = $urandom_range(0, 99);
            if (r < 75)
                pos = POS_W'($urandom_range(0, list_len + 1));
            else if (r < 90)
                pos = POS_W'($urandom_range(0, 255));
            else
                pos = (r < 95) ? 8'd255 : 8'd0;
            r = $urandom_range(0, 99);
            case (r % 5)
                0:       val = (r < 50) ? 32'h7FFF_FFFF : 32'h8000_0000;
                1:       val = (r < 50) ? 32'h0000_0000 : 32'hFFFF_FFFF;
                default: val = $urandom;
            endcase
            if ($urandom_range(0, 99) < 80) val = $urandom;
            send_word(op, pos, val, 1'b0, blank);
        end
        no_stall      = 1'b0;
        s_axis_tvalid = 1'b0;

        while (result_q.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    initial begin
        aresetn        = 1'b0;
        s_axis_tvalid  = 1'b0;
        s_axis_tdata   = '0;
        m_axis_tready  = 1'b0;
        list_len       = 0;
        mismatches     = 0;
        idle_cycles    = 0;
        words_in       = 0;
        full_refusals  = 0;
        empty_refusals = 0;
        reads_done     = 0;
        peak_len       = 0;
        no_stall       = 1'b0;
        timed_out      = 1'b0;
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        fork
            run_stimulus();
            begin
                wait (idle_cycles >= WATCHDOG_LIMIT);
                timed_out = 1'b1;
            end
        join_any

        if (timed_out) begin
            $display("watchdog: no word moved for %0d cycles, %0d results outstanding",
                     WATCHDOG_LIMIT, result_q.size());
            $display("RESULT: ERROR");
        end else begin
            $display("%0d requests sent, peak fill %0d of %0d, %0d successful reads",
                     words_in, peak_len, LIST_DEPTH, reads_done);
            $display("refusals: %0d on a full list, %0d on an empty list; %0d mismatches",
                     full_refusals, empty_refusals, mismatches);
            if (mismatches == 0)
                $display("RESULT: OK");
            else
                $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
